// File: src/ps2_mouse_packet_cursor_tracker_macros.svh
// Assertion macros shared by the cursor tracker modules.
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PMCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmct same-cycle assertion failed");

// Next-cycle implication, checked outside reset.
`define PMCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmct next-cycle assertion failed");

`endif

// File: src/pmct_pkg.sv
// Types and constants of the PS/2 mouse packet cursor tracker.
package pmct_pkg;

    localparam int RX_BYTE_W     = 8;
    localparam int OUT_COORD_W   = 11;
    localparam int OUT_BUTTON_W  = 3;
    localparam int OUT_COUNT_W   = 32;
    localparam int OUT_DATA_W    = 64;
    localparam int CFG_SIZE_W    = 12;
    localparam int MOVE_W        = 9;

    localparam int SYNC_BIT      = 3;
    localparam int X_SIGN_BIT    = 4;
    localparam int Y_SIGN_BIT    = 5;
    localparam int X_OVF_BIT     = 6;
    localparam int Y_OVF_BIT     = 7;

    localparam logic [CFG_SIZE_W-1:0] WIDTH_RESET  = 12'd80;
    localparam logic [CFG_SIZE_W-1:0] HEIGHT_RESET = 12'd25;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_X      = 2'd1,
        POS_Y      = 2'd2
    } pmct_pos_t;

    typedef enum logic [0:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } pmct_reg_t;

    // One good packet, reduced to what the cursor update needs.
    typedef struct packed {
        logic [OUT_BUTTON_W-1:0] buttons;
        logic [MOVE_W-1:0]       dx;
        logic [MOVE_W-1:0]       dy;
    } pmct_move_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pmct_qstat_t;

endpackage

// File: src/pmct_queue.sv
// Short queue of decoded packets between the byte front end and the cursor back end.
`include "ps2_mouse_packet_cursor_tracker_macros.svh"

module pmct_queue
    import pmct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  pmct_move_t  push_data,
    input  logic        pop,
    output pmct_move_t  pop_data,
    output pmct_qstat_t qstat
);

    pmct_move_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_next;

    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign pop_data    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `PMCT_ASSERT_NOW(a_pop_not_empty, clk, rst_n, pop, count_reg != '0)
    `PMCT_ASSERT_NEXT(a_push_grows, clk, rst_n, push && !pop,
        count_reg == QCNT_W'($past(count_reg) + 1'b1))
    `PMCT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH))

endmodule

// File: src/pmct_front.sv
// Byte front end: finds headers, assembles packets and drops overflowed ones.
module pmct_front
    import pmct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [RX_BYTE_W-1:0] in_byte,
    output logic                 in_ready,
    input  pmct_qstat_t          qstat,
    output logic                 push,
    output pmct_move_t           push_data
);

    pmct_pos_t            pos_reg;
    pmct_pos_t            pos_next;
    logic [RX_BYTE_W-1:0] header_reg;
    logic [RX_BYTE_W-1:0] x_move_reg;
    logic                 accept;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            unique case (pos_reg)
                POS_HEADER: pos_next = in_byte[SYNC_BIT] ? POS_X : POS_HEADER;
                POS_X:      pos_next = POS_Y;
                POS_Y:      pos_next = POS_HEADER;
                default:    pos_next = POS_HEADER;
            endcase
        end
    end

    always_comb
    begin
        push      = accept && (pos_reg == POS_Y)
                    && !header_reg[X_OVF_BIT] && !header_reg[Y_OVF_BIT];
        push_data.buttons = header_reg[OUT_BUTTON_W-1:0];
        push_data.dx      = {header_reg[X_SIGN_BIT], x_move_reg};
        push_data.dy      = {header_reg[Y_SIGN_BIT], in_byte};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HEADER;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (pos_reg == POS_HEADER) && in_byte[SYNC_BIT])
        begin
            header_reg <= in_byte;
        end
        if (accept && (pos_reg == POS_X))
        begin
            x_move_reg <= in_byte;
        end
    end

endmodule

// File: src/pmct_back.sv
// Cursor back end: moves and clamps the cursor, counts packets, holds the result register.
`include "ps2_mouse_packet_cursor_tracker_macros.svh"

module pmct_back
    import pmct_pkg::*;
#(
    parameter int COORD_BITS = 11,
    parameter int COUNT_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CFG_SIZE_W-1:0] screen_width,
    input  logic [CFG_SIZE_W-1:0] screen_height,
    input  pmct_qstat_t           qstat,
    input  pmct_move_t            pop_data,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    // Signed working width that holds a moved coordinate and any clamp limit.
    localparam int CW = (COORD_BITS + 2 > CFG_SIZE_W + 1) ? COORD_BITS + 2 : CFG_SIZE_W + 1;

    logic [COORD_BITS-1:0]   col_reg;
    logic [COORD_BITS-1:0]   row_reg;
    logic [COUNT_BITS-1:0]   cnt_reg;
    logic                    out_valid_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic [COORD_BITS-1:0]   col_next;
    logic [COORD_BITS-1:0]   row_next;
    logic [COUNT_BITS-1:0]   cnt_next;
    logic signed [CW-1:0]    col_sum;
    logic signed [CW-1:0]    row_sum;
    logic [COORD_BITS+OUT_COORD_W-1:0] col_ext;
    logic [COORD_BITS+OUT_COORD_W-1:0] row_ext;
    logic [COUNT_BITS+OUT_COUNT_W-1:0] cnt_ext;

    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic signed [CW-1:0]  v,
        input logic [CFG_SIZE_W-1:0] size
    );
        logic [CW-1:0] lim;
        logic [CW-1:0] coord_max;
        logic [CFG_SIZE_W-1:0] size_m1;
        size_m1   = (size == '0) ? '0 : size - 1'b1;
        coord_max = {{(CW - COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};
        lim       = {{(CW - CFG_SIZE_W){1'b0}}, size_m1};
        if (lim > coord_max)
        begin
            lim = coord_max;
        end
        if (v[CW-1])
        begin
            clamp_coord = '0;
        end
        else if (unsigned'(v) > lim)
        begin
            clamp_coord = lim[COORD_BITS-1:0];
        end
        else
        begin
            clamp_coord = v[COORD_BITS-1:0];
        end
    endfunction

    assign pop       = !qstat.empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        // Row moves opposite to the mouse Y so that down is positive.
        col_sum  = signed'({{(CW - COORD_BITS){1'b0}}, col_reg})
                   + signed'({{(CW - MOVE_W){pop_data.dx[MOVE_W-1]}}, pop_data.dx});
        row_sum  = signed'({{(CW - COORD_BITS){1'b0}}, row_reg})
                   - signed'({{(CW - MOVE_W){pop_data.dy[MOVE_W-1]}}, pop_data.dy});
        col_next = clamp_coord(col_sum, screen_width);
        row_next = clamp_coord(row_sum, screen_height);
        cnt_next = cnt_reg + 1'b1;
        col_ext  = {{OUT_COORD_W{1'b0}}, col_next};
        row_ext  = {{OUT_COORD_W{1'b0}}, row_next};
        cnt_ext  = {{OUT_COUNT_W{1'b0}}, cnt_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                col_reg       <= col_next;
                row_reg       <= row_next;
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= {{(OUT_DATA_W - 2 * OUT_COORD_W - OUT_BUTTON_W - OUT_COUNT_W){1'b0}},
                             cnt_ext[OUT_COUNT_W-1:0],
                             pop_data.buttons,
                             row_ext[OUT_COORD_W-1:0],
                             col_ext[OUT_COORD_W-1:0]};
        end
    end

    `PMCT_ASSERT_NEXT(a_pop_fills_output, clk, rst_n, pop, out_valid_reg)
    `PMCT_ASSERT_NEXT(a_stall_holds_cursor, clk, rst_n, out_valid_reg && !out_ready,
        $stable(col_reg) && $stable(row_reg) && $stable(cnt_reg))
    `PMCT_ASSERT_NEXT(a_pop_counts_one, clk, rst_n, pop,
        cnt_reg == COUNT_BITS'($past(cnt_reg) + 1'b1))

endmodule

// File: src/ps2_mouse_packet_cursor_tracker.sv
// Top level of the PS/2 mouse packet decoder and cursor tracker.
//
// Raw mouse bytes enter on the s_axis channel, one byte per request. Bytes are
// grouped into header, X and Y packets; while a header is expected, bytes with
// bit 3 clear are dropped. Packets with an overflow bit set give no result.
// Every good packet yields one request on m_axis with the clamped cursor
// column and row, the button bits and the running packet count.
// Throughput is one byte per cycle while the packet queue is not full. The
// third byte of a good packet pushes it into the packet queue, from which the
// cursor update loads the output register once that register is free.
// When the receiver stalls, the output register holds its result, the
// two-entry packet queue fills, and s_axis_tready then drops until the back
// end drains a packet.
// Reset clears the cursor, the packet count and the byte position and sets
// the screen to 80 columns by 25 rows. screen_width lies at address 0 and
// screen_height at address 4 of the APB port; write them only while idle.
module ps2_mouse_packet_cursor_tracker
    import pmct_pkg::*;
#(
    parameter int COORD_BITS = 11,
    parameter int COUNT_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [7:0] rx_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [10:0] cursor_col, [21:11] cursor_row, [24:22] button_bits,
    // [56:25] packets_seen, [63:57] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [CFG_SIZE_W-1:0] width_reg;
    logic [CFG_SIZE_W-1:0] height_reg;
    logic                  cfg_write;
    pmct_reg_t             cfg_sel;
    logic                  push;
    logic                  pop;
    pmct_move_t            push_data;
    pmct_move_t            pop_data;
    pmct_qstat_t           qstat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = pmct_reg_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_sel)
            REG_SCREEN_WIDTH:  prdata = {{(32 - CFG_SIZE_W){1'b0}}, width_reg};
            REG_SCREEN_HEIGHT: prdata = {{(32 - CFG_SIZE_W){1'b0}}, height_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_SCREEN_WIDTH:  width_reg  <= pwdata[CFG_SIZE_W-1:0];
                REG_SCREEN_HEIGHT: height_reg <= pwdata[CFG_SIZE_W-1:0];
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    pmct_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_byte   (s_axis_tdata),
        .in_ready  (s_axis_tready),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    pmct_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    pmct_back #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .qstat         (qstat),
        .pop_data      (pop_data),
        .pop           (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_data      (m_axis_tdata)
    );

endmodule
